/* src/tlvp_pkg.sv */
// Shared definitions for the BER-TLV stream parser: phase, role and error codes,
// stack sizing and the per-byte result record. No dependencies.
package tlvp_pkg;

    localparam int MAX_DEPTH = 8;
    localparam int OPEN_W    = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    localparam logic [1:0] PH_TAG  = 2'd0;
    localparam logic [1:0] PH_TAGX = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;
    localparam logic [1:0] PH_VAL  = 2'd3;

    localparam logic [1:0] ROLE_TAG     = 2'd0;
    localparam logic [1:0] ROLE_LEN     = 2'd1;
    localparam logic [1:0] ROLE_VALUE   = 2'd2;
    localparam logic [1:0] ROLE_DISCARD = 2'd3;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_LEN_FORM = 2'd1;
    localparam logic [1:0] ERR_OVERRUN  = 2'd2;
    localparam logic [1:0] ERR_TOO_DEEP = 2'd3;

    localparam logic [4:0] TAG_EXT_MASK = 5'h1F;
    localparam logic [7:0] LEN_LONG     = 8'h80;
    localparam logic [7:0] LEN_LONG_MAX = 8'h83;

    typedef struct packed {
        logic [1:0]  byte_role;
        logic [7:0]  data_out;
        logic        header_done;
        logic [31:0] tag_value;
        logic [23:0] value_length;
        logic        is_constructed;
        logic [3:0]  nest_depth;
        logic [3:0]  elements_closed;
        logic [1:0]  error_code;
    } result_t;

endpackage

/* src/ber_tlv_stream_parser.sv */
// BER-TLV stream parser: classifies each byte of a TLV stream and reports headers,
// nesting depth, element closings and sticky errors. Uses tlvp_core, tlvp_out_buf.
//
// One result beat per input byte, one byte per clock while in_stall is low; each
// result is registered in the buffer. The parse step finishes within the cycle the
// byte is accepted, with all open stack levels counting down in parallel. Results
// wait in a two-entry buffer; in_stall rises only when both entries are occupied.
// Assert new_message with the first byte of each message to clear the stack and
// any latched error; after an error every byte is discarded until then.
module ber_tlv_stream_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        new_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  byte_role,
    output logic [7:0]  data_out,
    output logic        header_done,
    output logic [31:0] tag_value,
    output logic [23:0] value_length,
    output logic        is_constructed,
    output logic [3:0]  nest_depth,
    output logic [3:0]  elements_closed,
    output logic [1:0]  error_code
);

    logic              take;
    logic              full;
    tlvp_pkg::result_t step_result;
    tlvp_pkg::result_t head;

    assign in_stall = full;
    assign take     = in_valid && !full;

    tlvp_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .data_byte   (data_byte),
        .new_message (new_message),
        .result      (step_result)
    );

    tlvp_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (step_result),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign byte_role       = head.byte_role;
    assign data_out        = head.data_out;
    assign header_done     = head.header_done;
    assign tag_value       = head.tag_value;
    assign value_length    = head.value_length;
    assign is_constructed  = head.is_constructed;
    assign nest_depth      = head.nest_depth;
    assign elements_closed = head.elements_closed;
    assign error_code      = head.error_code;

endmodule

/* src/tlvp_core.sv */
// Per-byte BER-TLV parse step: header decode, nesting stack and sticky error.
// One byte per cycle while take is high; result is combinational from state. Uses tlvp_pkg.
module tlvp_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        data_byte,
    input  logic              new_message,
    output tlvp_pkg::result_t result
);

    logic [1:0]                  phase_reg, phase_next;
    logic [31:0]                 tag_accum_reg, tag_accum_next;
    logic [2:0]                  tag_cnt_reg, tag_cnt_next;
    logic [23:0]                 len_accum_reg, len_accum_next;
    logic [1:0]                  len_left_reg, len_left_next;
    logic [23:0]                 prim_left_reg, prim_left_next;
    logic [tlvp_pkg::OPEN_W-1:0] open_reg, open_next;
    logic [1:0]                  err_reg, err_next;
    logic [23:0]                 lvl_reg  [tlvp_pkg::MAX_DEPTH];
    logic [23:0]                 lvl_next [tlvp_pkg::MAX_DEPTH];

    always_comb
    begin
        logic [1:0]                  e_phase;
        logic [31:0]                 e_tag;
        logic [2:0]                  e_cnt;
        logic [23:0]                 e_lacc;
        logic [1:0]                  e_lleft;
        logic [23:0]                 e_prim;
        logic [tlvp_pkg::OPEN_W-1:0] e_open;
        logic [tlvp_pkg::OPEN_W-1:0] open_m1;
        logic [tlvp_pkg::OPEN_W-1:0] open_push;
        logic [tlvp_pkg::OPEN_W-1:0] zeros;
        logic [1:0]                  err;
        logic                        done;
        logic                        cons;
        logic                        push;
        logic [23:0]                 len;
        logic [23:0]                 need;
        logic [24:0]                 r;
        logic [7:0]                  first;
        logic [3:0]                  closed;
        logic [23:0]                 dec [tlvp_pkg::MAX_DEPTH];

        e_phase = new_message ? tlvp_pkg::PH_TAG : phase_reg;
        e_tag   = new_message ? 32'd0 : tag_accum_reg;
        e_cnt   = new_message ? 3'd0 : tag_cnt_reg;
        e_lacc  = new_message ? 24'd0 : len_accum_reg;
        e_lleft = new_message ? 2'd0 : len_left_reg;
        e_prim  = new_message ? 24'd0 : prim_left_reg;
        e_open  = new_message ? '0 : open_reg;

        phase_next     = e_phase;
        tag_accum_next = e_tag;
        tag_cnt_next   = e_cnt;
        len_accum_next = e_lacc;
        len_left_next  = e_lleft;
        prim_left_next = e_prim;
        open_next      = e_open;
        err_next       = new_message ? tlvp_pkg::ERR_NONE : err_reg;

        result          = '0;
        result.data_out = data_byte;

        err       = tlvp_pkg::ERR_NONE;
        done      = 1'b0;
        cons      = 1'b0;
        push      = 1'b0;
        len       = 24'd0;
        need      = 24'd0;
        r         = 25'h1000000;
        first     = 8'd0;
        closed    = 4'd0;
        zeros     = '0;
        open_m1   = e_open - 1'b1;
        open_push = e_open;

        for (int i = 0; i < tlvp_pkg::MAX_DEPTH; i++)
        begin
            lvl_next[i] = lvl_reg[i];
            dec[i]      = lvl_reg[i] - {23'd0, (lvl_reg[i] != 24'd0)};
        end

        if (err_next != tlvp_pkg::ERR_NONE || e_open > tlvp_pkg::OPEN_W'(tlvp_pkg::MAX_DEPTH))
        begin
            if (err_next == tlvp_pkg::ERR_NONE)
            begin
                err_next = tlvp_pkg::ERR_OVERRUN;
            end
            open_next         = '0;
            result.byte_role  = tlvp_pkg::ROLE_DISCARD;
            result.error_code = err_next;
        end
        else
        begin
            for (int i = 0; i < tlvp_pkg::MAX_DEPTH; i++)
            begin
                if (tlvp_pkg::OPEN_W'(i) < e_open)
                begin
                    lvl_next[i] = dec[i];
                end
            end

            unique case (e_phase)
                tlvp_pkg::PH_TAG:
                begin
                    result.byte_role = tlvp_pkg::ROLE_TAG;
                    tag_accum_next   = {24'd0, data_byte};
                    tag_cnt_next     = 3'd1;
                    phase_next       = (data_byte[4:0] == tlvp_pkg::TAG_EXT_MASK)
                                       ? tlvp_pkg::PH_TAGX : tlvp_pkg::PH_LEN;
                    len_left_next    = 2'd0;
                    len_accum_next   = 24'd0;
                end
                tlvp_pkg::PH_TAGX:
                begin
                    result.byte_role = tlvp_pkg::ROLE_TAG;
                    tag_accum_next   = {e_tag[23:0], data_byte};
                    tag_cnt_next     = e_cnt + 3'd1;
                    if (!(data_byte[7] && tag_cnt_next < 3'd4))
                    begin
                        phase_next = tlvp_pkg::PH_LEN;
                    end
                end
                tlvp_pkg::PH_LEN:
                begin
                    result.byte_role = tlvp_pkg::ROLE_LEN;
                    if (e_lleft == 2'd0)
                    begin
                        if (data_byte < tlvp_pkg::LEN_LONG)
                        begin
                            len  = {16'd0, data_byte};
                            done = 1'b1;
                        end
                        else if (data_byte > tlvp_pkg::LEN_LONG
                                 && data_byte <= tlvp_pkg::LEN_LONG_MAX)
                        begin
                            len_left_next  = data_byte[1:0];
                            len_accum_next = 24'd0;
                        end
                        else
                        begin
                            err = tlvp_pkg::ERR_LEN_FORM;
                        end
                    end
                    else
                    begin
                        len_accum_next = {e_lacc[15:0], data_byte};
                        len_left_next  = e_lleft - 2'd1;
                        if (len_left_next == 2'd0)
                        begin
                            len  = len_accum_next;
                            done = 1'b1;
                        end
                    end
                end
                default:
                begin
                    result.byte_role = tlvp_pkg::ROLE_VALUE;
                    prim_left_next   = e_prim - {23'd0, (e_prim != 24'd0)};
                    if (prim_left_next == 24'd0)
                    begin
                        closed     = 4'd1;
                        phase_next = tlvp_pkg::PH_TAG;
                    end
                end
            endcase

            if (done)
            begin
                case (tag_cnt_next) inside
                    3'd0, 3'd1: first = tag_accum_next[7:0];
                    3'd2:       first = tag_accum_next[15:8];
                    3'd3:       first = tag_accum_next[23:16];
                    default:    first = tag_accum_next[31:24];
                endcase
                cons = first[5];
                if (!cons && len != 24'd0)
                begin
                    phase_next     = tlvp_pkg::PH_VAL;
                    prim_left_next = len;
                end
                else
                begin
                    phase_next = tlvp_pkg::PH_TAG;
                    if (len == 24'd0)
                    begin
                        closed = closed + 4'd1;
                    end
                end
            end

            if (e_open != '0)
            begin
                r = {1'b0, dec[open_m1[tlvp_pkg::IDX_W-1:0]]};
            end

            if (phase_next == tlvp_pkg::PH_TAGX || phase_next == tlvp_pkg::PH_LEN)
            begin
                need = 24'd1;
            end
            else if (phase_next == tlvp_pkg::PH_VAL)
            begin
                need = prim_left_next;
            end
            else if (done && cons)
            begin
                need = len;
            end

            if (err == tlvp_pkg::ERR_NONE)
            begin
                if ({1'b0, need} > r)
                begin
                    err = tlvp_pkg::ERR_OVERRUN;
                end
                else if (done && cons && len != 24'd0
                         && e_open >= tlvp_pkg::OPEN_W'(tlvp_pkg::MAX_DEPTH))
                begin
                    err = tlvp_pkg::ERR_TOO_DEEP;
                end
            end

            result.nest_depth = 4'(e_open);

            if (err != tlvp_pkg::ERR_NONE)
            begin
                err_next          = err;
                phase_next        = tlvp_pkg::PH_TAG;
                tag_accum_next    = 32'd0;
                tag_cnt_next      = 3'd0;
                len_accum_next    = 24'd0;
                len_left_next     = 2'd0;
                prim_left_next    = 24'd0;
                open_next         = '0;
                result.error_code = err;
            end
            else
            begin
                if (done)
                begin
                    result.header_done    = 1'b1;
                    result.tag_value      = tag_accum_next;
                    result.value_length   = len;
                    result.is_constructed = cons;
                    push                  = cons && len != 24'd0;
                end
                if (push)
                begin
                    lvl_next[e_open[tlvp_pkg::IDX_W-1:0]] = len;
                    open_push = e_open + 1'b1;
                end
                for (int i = 0; i < tlvp_pkg::MAX_DEPTH; i++)
                begin
                    if (tlvp_pkg::OPEN_W'(i) < open_push && lvl_next[i] == 24'd0)
                    begin
                        zeros = zeros + 1'b1;
                    end
                end
                open_next              = open_push - zeros;
                result.elements_closed = closed + 4'(zeros);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= tlvp_pkg::PH_TAG;
            tag_accum_reg <= 32'd0;
            tag_cnt_reg   <= 3'd0;
            len_accum_reg <= 24'd0;
            len_left_reg  <= 2'd0;
            prim_left_reg <= 24'd0;
            open_reg      <= '0;
            err_reg       <= tlvp_pkg::ERR_NONE;
        end
        else if (take)
        begin
            phase_reg     <= phase_next;
            tag_accum_reg <= tag_accum_next;
            tag_cnt_reg   <= tag_cnt_next;
            len_accum_reg <= len_accum_next;
            len_left_reg  <= len_left_next;
            prim_left_reg <= prim_left_next;
            open_reg      <= open_next;
            err_reg       <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < tlvp_pkg::MAX_DEPTH; i++)
            begin
                lvl_reg[i] <= lvl_next[i];
            end
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        open_reg <= tlvp_pkg::OPEN_W'(tlvp_pkg::MAX_DEPTH))
        else $error("nesting stack above its depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != tlvp_pkg::ERR_NONE |-> open_reg == '0)
        else $error("levels open while an error is latched");

    assert property (@(posedge clk) disable iff (!rst_n)
        take && !new_message && err_reg != tlvp_pkg::ERR_NONE |=> err_reg == $past(err_reg))
        else $error("latched error changed without message start");

    assert property (@(posedge clk) disable iff (!rst_n)
        take && result.byte_role == tlvp_pkg::ROLE_DISCARD
        |-> result.error_code != tlvp_pkg::ERR_NONE && result.header_done == 1'b0)
        else $error("discarded byte without error code");
`endif

endmodule

/* src/tlvp_out_buf.sv */
// Two-entry result buffer between the parse step and the output channel.
// Lets a new byte in while a result waits. Uses tlvp_pkg::result_t.
module tlvp_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tlvp_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output tlvp_pkg::result_t head
);

    logic [1:0]        count_reg, count_next;
    tlvp_pkg::result_t slot0_reg, slot0_next;
    tlvp_pkg::result_t slot1_reg, slot1_next;
    logic              pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign head      = slot0_reg;
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    slot0_next = push_data;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                begin
                    slot0_next = push_data;
                end
                else if (push)
                begin
                    slot1_next = push_data;
                    count_next = 2'd2;
                end
                else if (pop)
                begin
                    count_next = 2'd0;
                end
            end
            default:
            begin
                if (pop)
                begin
                    slot0_next = slot1_reg;
                    count_next = 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("beat written into a full result buffer");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 && !pop |=> $stable(slot1_reg) && count_reg == 2'd2)
        else $error("held result lost from buffer");
`endif

endmodule

/* sim/tlvp_checker.sv */
// Checker for the BER-TLV stream parser: tracks tag, length and nesting state per byte,
// predicts each result beat and compares it field by field. Depends on tlvp_pkg.
module tlvp_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        new_message,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  byte_role,
    input  logic [7:0]  data_out,
    input  logic        header_done,
    input  logic [31:0] tag_value,
    input  logic [23:0] value_length,
    input  logic        is_constructed,
    input  logic [3:0]  nest_depth,
    input  logic [3:0]  elements_closed,
    input  logic [1:0]  error_code,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [1:0]                  phase;
    logic [31:0]                 tag_acc;
    logic [2:0]                  tag_cnt;
    logic [23:0]                 len_acc;
    logic [1:0]                  len_left;
    logic [23:0]                 prim_left;
    logic [23:0]                 lvl_rem [tlvp_pkg::MAX_DEPTH];
    logic [tlvp_pkg::OPEN_W-1:0] open_lv;
    logic [1:0]                  err_lat;

    tlvp_pkg::result_t byte_results[$];
    tlvp_pkg::result_t want;
    int                mismatches;
    int                beat_idx;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: beat %0d: %s", $time, beat_idx, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s is %0h, should be %0h", name, got, exp_val));
    endtask

    function automatic void clear_parse();
        phase     = tlvp_pkg::PH_TAG;
        tag_acc   = '0;
        tag_cnt   = '0;
        len_acc   = '0;
        len_left  = '0;
        prim_left = '0;
    endfunction

    function automatic tlvp_pkg::result_t classify_byte(input logic [7:0] b, input logic nm);
        tlvp_pkg::result_t res;
        logic              done;
        logic              cons;
        logic [1:0]        err;
        logic [23:0]       len;
        logic [24:0]       room;
        logic [24:0]       need;
        logic [7:0]        first;
        int                cnt;
        int                closed;
        int                depth_before;
        int                i;

        res      = '0;
        res.data_out = b;
        done     = 1'b0;
        cons     = 1'b0;
        err      = tlvp_pkg::ERR_NONE;
        len      = '0;
        closed   = 0;

        if (nm)
        begin
            clear_parse();
            open_lv = '0;
            err_lat = tlvp_pkg::ERR_NONE;
        end

        if (err_lat != tlvp_pkg::ERR_NONE || open_lv > tlvp_pkg::MAX_DEPTH)
        begin
            if (err_lat == tlvp_pkg::ERR_NONE)
                err_lat = tlvp_pkg::ERR_OVERRUN;
            open_lv        = '0;
            res.byte_role  = tlvp_pkg::ROLE_DISCARD;
            res.error_code = err_lat;
            return res;
        end

        depth_before = open_lv;
        for (i = 0; i < tlvp_pkg::MAX_DEPTH; i++)
            if (i < open_lv && lvl_rem[i] != 0)
                lvl_rem[i] = lvl_rem[i] - 1'b1;

        case (phase)
            tlvp_pkg::PH_TAG:
            begin
                res.byte_role = tlvp_pkg::ROLE_TAG;
                tag_acc  = {24'd0, b};
                tag_cnt  = 3'd1;
                phase    = (b[4:0] == tlvp_pkg::TAG_EXT_MASK)
                           ? tlvp_pkg::PH_TAGX : tlvp_pkg::PH_LEN;
                len_left = '0;
                len_acc  = '0;
            end
            tlvp_pkg::PH_TAGX:
            begin
                res.byte_role = tlvp_pkg::ROLE_TAG;
                tag_acc = {tag_acc[23:0], b};
                tag_cnt = tag_cnt + 3'd1;
                if (!(b[7] && tag_cnt < 3'd4))
                    phase = tlvp_pkg::PH_LEN;
            end
            tlvp_pkg::PH_LEN:
            begin
                res.byte_role = tlvp_pkg::ROLE_LEN;
                if (len_left == 0)
                begin
                    if (b < tlvp_pkg::LEN_LONG)
                    begin
                        len  = {16'd0, b};
                        done = 1'b1;
                    end
                    else if (b > tlvp_pkg::LEN_LONG && b <= tlvp_pkg::LEN_LONG_MAX)
                    begin
                        len_left = b[1:0];
                        len_acc  = '0;
                    end
                    else
                        err = tlvp_pkg::ERR_LEN_FORM;
                end
                else
                begin
                    len_acc  = {len_acc[15:0], b};
                    len_left = len_left - 2'd1;
                    if (len_left == 0)
                    begin
                        len  = len_acc;
                        done = 1'b1;
                    end
                end
            end
            default:
            begin
                res.byte_role = tlvp_pkg::ROLE_VALUE;
                if (prim_left != 0)
                    prim_left = prim_left - 1'b1;
                if (prim_left == 0)
                begin
                    closed++;
                    phase = tlvp_pkg::PH_TAG;
                end
            end
        endcase

        if (done)
        begin
            cnt   = (tag_cnt < 1) ? 1 : (tag_cnt > 4) ? 4 : int'(tag_cnt);
            first = 8'(tag_acc >> (8 * (cnt - 1)));
            cons  = first[5];
            if (!cons && len != 0)
            begin
                phase     = tlvp_pkg::PH_VAL;
                prim_left = len;
            end
            else
            begin
                phase = tlvp_pkg::PH_TAG;
                if (len == 0)
                    closed++;
            end
        end

        room = 25'h1000000;
        if (open_lv > 0 && open_lv <= tlvp_pkg::MAX_DEPTH)
            room = {1'b0, lvl_rem[open_lv - 1'b1]};
        if (phase == tlvp_pkg::PH_TAGX || phase == tlvp_pkg::PH_LEN)
            need = 25'd1;
        else if (phase == tlvp_pkg::PH_VAL)
            need = {1'b0, prim_left};
        else if (done && cons)
            need = {1'b0, len};
        else
            need = '0;

        if (err == tlvp_pkg::ERR_NONE)
        begin
            if (need > room)
                err = tlvp_pkg::ERR_OVERRUN;
            else if (done && cons && len != 0 && open_lv >= tlvp_pkg::MAX_DEPTH)
                err = tlvp_pkg::ERR_TOO_DEEP;
        end

        res.nest_depth = (depth_before > 15) ? 4'd15 : 4'(depth_before);
        if (err != tlvp_pkg::ERR_NONE)
        begin
            err_lat = err;
            clear_parse();
            open_lv = '0;
            res.error_code = err;
            return res;
        end

        if (done)
        begin
            res.header_done    = 1'b1;
            res.tag_value      = tag_acc;
            res.value_length   = len;
            res.is_constructed = cons;
            if (cons && len != 0)
            begin
                lvl_rem[open_lv] = len;
                open_lv = open_lv + 1'b1;
            end
        end
        while (open_lv > 0 && lvl_rem[open_lv - 1'b1] == 0)
        begin
            open_lv = open_lv - 1'b1;
            closed++;
        end
        res.elements_closed = (closed > 15) ? 4'd15 : 4'(closed);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            open_lv = '0;
            err_lat = tlvp_pkg::ERR_NONE;
            byte_results.delete();
            mismatches = 0;
            beat_idx   = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                byte_results.push_back(classify_byte(data_byte, new_message));
            if (out_valid && !out_stall)
            begin
                if (byte_results.size() == 0)
                    report_mismatch("result beat with no byte outstanding");
                else
                begin
                    want = byte_results.pop_front();
                    check_field("byte_role", 32'(byte_role), 32'(want.byte_role));
                    check_field("data_out", 32'(data_out), 32'(want.data_out));
                    check_field("header_done", 32'(header_done), 32'(want.header_done));
                    check_field("tag_value", tag_value, want.tag_value);
                    check_field("value_length", 32'(value_length), 32'(want.value_length));
                    check_field("is_constructed", 32'(is_constructed),
                                32'(want.is_constructed));
                    check_field("nest_depth", 32'(nest_depth), 32'(want.nest_depth));
                    check_field("elements_closed", 32'(elements_closed),
                                32'(want.elements_closed));
                    check_field("error_code", 32'(error_code), 32'(want.error_code));
                end
                beat_idx++;
            end
            fail_count <= mismatches;
            pending    <= byte_results.size();
        end
    end

endmodule

/* sim/tb.sv */
// Testbench top for ber_tlv_stream_parser: drives directed and random TLV byte streams
// with random idling on both channels and gives the verdict. Uses tlvp_pkg, tlvp_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 500;
    localparam int QUIET_BYTES  = 80;
    localparam int HOLD_CYCLES  = 300;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        new_message;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  byte_role;
    logic [7:0]  data_out;
    logic        header_done;
    logic [31:0] tag_value;
    logic [23:0] value_length;
    logic        is_constructed;
    logic [3:0]  nest_depth;
    logic [3:0]  elements_closed;
    logic [1:0]  error_code;
    int          fail_count;
    int          pending;

    logic        quiet;
    logic        hold_req;
    logic        calm;
    logic [7:0]  msg_q[$];
    int          sent;

    ber_tlv_stream_parser u_top (.*);

    tlvp_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 11) == 0)
            begin
                out_stall <= 1'b1;
                n = $urandom_range(1, 18);
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic nm);
        int n;
        if (!quiet && !calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            n = $urandom_range(1, 18);
            repeat (n) @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        new_message <= nm;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
    endtask

    task automatic send_msg();
        foreach (msg_q[k])
            send_byte(msg_q[k], k == 0);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic put_tag(input logic cons);
        logic [7:0] t;
        int         nb;
        int         k;
        nb = ($urandom_range(0, 2) != 0) ? 1 : $urandom_range(2, 4);
        t = 8'($urandom);
        t[5] = cons;
        if (nb == 1)
        begin
            if (t[4:0] == tlvp_pkg::TAG_EXT_MASK)
                t[0] = 1'b0;
        end
        else
            t[4:0] = tlvp_pkg::TAG_EXT_MASK;
        msg_q.push_back(t);
        for (k = 2; k <= nb; k++)
        begin
            t = 8'($urandom);
            if (k < nb)
                t[7] = 1'b1;
            else if (k < 4)
                t[7] = 1'b0;
            msg_q.push_back(t);
        end
    endtask

    task automatic put_length(input int pos, input int len);
        int need;
        int nb;
        int k;
        if (len < 128 && $urandom_range(0, 3) != 0)
            msg_q.insert(pos, 8'(len));
        else
        begin
            need = (len < 256) ? 1 : (len < 65536) ? 2 : 3;
            nb = $urandom_range(need, 3);
            msg_q.insert(pos, tlvp_pkg::LEN_LONG | 8'(nb));
            for (k = 0; k < nb; k++)
                msg_q.insert(pos + 1 + k, 8'(len >> (8 * (nb - 1 - k))));
        end
    endtask

    // chain > 0 forces that many nested constructed levels, one child each
    task automatic put_element(input int lvl, input int chain);
        logic cons;
        int   pos;
        int   len;
        int   n;
        int   k;
        cons = (chain > 0) || ($urandom_range(0, 1) == 1);
        put_tag(cons);
        pos = msg_q.size();
        if (chain > 0)
            put_element(lvl + 1, chain - 1);
        else if (cons)
        begin
            n = (lvl >= tlvp_pkg::MAX_DEPTH || msg_q.size() > 100) ? 0 : $urandom_range(0, 3);
            for (k = 0; k < n; k++)
                put_element(lvl + 1, 0);
        end
        else
        begin
            len = ($urandom_range(0, 39) == 0) ? $urandom_range(128, 140)
                                               : $urandom_range(0, 4);
            for (k = 0; k < len; k++)
                msg_q.push_back(8'($urandom));
        end
        put_length(pos, msg_q.size() - pos);
    endtask

    initial
    begin
        int kind;
        int n;
        int k;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        data_byte   = '0;
        new_message = 1'b0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        calm        = 1'b0;
        sent        = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        msg_q = '{8'h00, 8'h00, 8'h01, 8'h00};
        send_msg();
        msg_q = '{8'h1F, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        send_msg();
        msg_q = '{8'h21, 8'h02, 8'h04, 8'h01};
        send_msg();
        msg_q = '{8'h05, 8'h80, 8'h00};
        send_msg();
        msg_q = '{8'h30, 8'h05, 8'h31, 8'h03, 8'h02, 8'h01, 8'h77};
        send_msg();
        msg_q = '{8'h0A, 8'h84};
        send_msg();
        drain();

        // hold the result side while bytes keep coming
        hold_req <= 1'b1;
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            if (sent >= RANDOM_BYTES - QUIET_BYTES)
                quiet <= 1'b1;
            calm = ($urandom_range(0, 3) == 0);
            msg_q.delete();
            kind = $urandom_range(0, 99);
            if (kind < 10)
            begin
                n = $urandom_range(1, 12);
                for (k = 0; k < n; k++)
                    send_byte(8'($urandom), (k == 0) || ($urandom_range(0, 7) == 0));
            end
            else
            begin
                if (kind < 22)
                    put_element(0, $urandom_range(8, 9));
                else
                begin
                    n = $urandom_range(1, 3);
                    for (k = 0; k < n; k++)
                        put_element(0, 0);
                end
                if (kind >= 22 && kind < 36)
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        n = $urandom_range(1, msg_q.size());
                        while (msg_q.size() > n)
                            void'(msg_q.pop_back());
                    end
                    else
                        msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom);
                    n = $urandom_range(0, 3);
                    for (k = 0; k < n; k++)
                        msg_q.push_back(8'($urandom));
                end
                send_msg();
            end
            if ($urandom_range(0, 29) == 0)
                drain();
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
